[hw/rtl/pbc_pkg.sv]
// pbc_pkg: shared types, constants and the tone table of the proximity beep controller
// no dependencies; used by pbc_div, proximity_beep_controller_core and pbc_checker
package pbc_pkg;

    localparam int DistW    = 10;
    localparam int ThrW     = 10;
    localparam int MinW     = 10;
    localparam int MaxW     = 12;
    localparam int BeepW    = 10;
    localparam int ToneW    = 11;
    localparam int PauseW   = 13;
    localparam int CfgW     = 12;
    localparam int CfgIdxW  = 2;
    localparam int SensW    = 2;

    // shared multiplier and divider widths
    localparam int MulAW    = 20;
    localparam int MulBW    = 12;
    localparam int ProdW    = MulAW + MulBW;
    localparam int DivisorW = 20;
    localparam int QuoW     = 12;

    typedef enum logic [CfgIdxW-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_MIN_PAUSE = 2'd1,
        REG_MAX_PAUSE = 2'd2,
        REG_BEEP_LEN  = 2'd3
    } cfg_idx_t;

    typedef enum logic [SensW-1:0] {
        SENSOR_FRONT = 2'd0,
        SENSOR_LEFT  = 2'd1,
        SENSOR_RIGHT = 2'd2,
        SENSOR_BACK  = 2'd3
    } sensor_t;

    localparam logic [ThrW-1:0]   THR_RESET      = 10'd50;
    localparam logic [MinW-1:0]   MIN_RESET      = 10'd50;
    localparam logic [MaxW-1:0]   MAX_RESET      = 12'd500;
    localparam logic [BeepW-1:0]  BEEP_RESET     = 10'd50;
    localparam logic [DistW-1:0]  CONT_LIMIT     = 10'd4;
    localparam logic [DistW:0]    APPROACH_LIMIT = 11'd5;
    localparam logic [PauseW-1:0] LOOP_WAIT      = 13'd10;
    localparam logic [PauseW-1:0] IDLE_PAUSE     = 13'd110;

    localparam logic [ToneW-1:0]  TONE_FRONT     = 11'd1000;
    localparam logic [ToneW-1:0]  TONE_LEFT      = 11'd800;
    localparam logic [ToneW-1:0]  TONE_RIGHT     = 11'd1200;
    localparam logic [ToneW-1:0]  TONE_BACK      = 11'd600;

    typedef struct packed {
        logic [DistW-1:0] dist_front;
        logic [DistW-1:0] dist_left;
        logic [DistW-1:0] dist_right;
        logic [DistW-1:0] dist_back;
    } in_beat_t;

    typedef struct packed {
        logic              obstacle_seen;
        logic [SensW-1:0]  nearest_sensor;
        logic [ToneW-1:0]  tone_hz;
        logic              continuous_tone;
        logic [BeepW-1:0]  beep_ms;
        logic [PauseW-1:0] pause_ms;
    } out_beat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    function automatic logic [ToneW-1:0] tone_of(input logic [SensW-1:0] sel);
        logic [ToneW-1:0] t;
        case (sel)
            SENSOR_FRONT: t = TONE_FRONT;
            SENSOR_LEFT:  t = TONE_LEFT;
            SENSOR_RIGHT: t = TONE_RIGHT;
            SENSOR_BACK:  t = TONE_BACK;
            default:      t = TONE_FRONT;
        endcase
        return t;
    endfunction

endpackage

[hw/rtl/pbc_div.sv]
// pbc_div: restoring divider, one quotient bit per cycle
// depends on pbc_pkg; quotient is known to fit in pbc_pkg::QuoW bits
module pbc_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [pbc_pkg::ProdW-1:0]      dividend,
    input  logic [pbc_pkg::DivisorW-1:0]   divisor,
    output logic [pbc_pkg::QuoW-1:0]       quotient,
    output pbc_pkg::div_sts_t              sts
);

    localparam int DsrW = pbc_pkg::DivisorW + pbc_pkg::QuoW - 1;
    localparam int CntW = $clog2(pbc_pkg::QuoW);

    logic [pbc_pkg::ProdW-1:0] rem_reg;
    logic [DsrW-1:0]           dsr_reg;
    logic [pbc_pkg::QuoW-1:0]  q_reg;
    logic [CntW-1:0]           cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [pbc_pkg::ProdW:0]   diff;
    logic                      ge;

    assign diff = {1'b0, rem_reg} - {{(pbc_pkg::ProdW + 1 - DsrW){1'b0}}, dsr_reg};
    assign ge   = ~diff[pbc_pkg::ProdW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(pbc_pkg::QuoW - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // divisor starts aligned to the top quotient bit and walks right
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dsr_reg <= {divisor, {(pbc_pkg::QuoW - 1){1'b0}}};
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= diff[pbc_pkg::ProdW-1:0];
            end
            q_reg   <= {q_reg[pbc_pkg::QuoW-2:0], ge};
            dsr_reg <= dsr_reg >> 1;
        end
    end

    assign quotient = q_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

[hw/rtl/proximity_beep_controller_core.sv]
// proximity_beep_controller_core: nearest-sensor pick, tone select and beep pause timing
// depends on pbc_pkg and pbc_div
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | s_data  (pbc_pkg::in_beat_t)
//  m_      | out       | m_valid / m_ready    | m_data  (pbc_pkg::out_beat_t)
//  cfg_    | in        | cfg_we, no wait      | cfg_index, cfg_wdata
//
// a beat first scans the four sensors; a silent or continuous beat then finishes
// (beep mode adds 3 passes through the shared multiplier and 12 divider steps)
// the 12-step restoring divider dominates beep mode; s_ready is high only when idle
// results sit in an output register, so the next beat is accepted while one waits
// aresetn is synchronous; it restores the register defaults and the stored distance
module proximity_beep_controller_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pbc_pkg::in_beat_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pbc_pkg::out_beat_t            m_data,
    input  logic                          cfg_we,
    input  logic [pbc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [pbc_pkg::CfgW-1:0]      cfg_wdata
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SCAN = 7'b0000010,
        ST_SQ   = 7'b0000100,
        ST_THR  = 7'b0001000,
        ST_PROD = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [pbc_pkg::ThrW-1:0]  thr_reg;
    logic [pbc_pkg::MinW-1:0]  min_reg;
    logic [pbc_pkg::MaxW-1:0]  max_reg;
    logic [pbc_pkg::BeepW-1:0] beep_reg;
    logic [pbc_pkg::DistW-1:0] last_reg;

    pbc_pkg::in_beat_t         in_reg;
    logic [pbc_pkg::SensW-1:0] idx_reg;
    logic                      found_reg, found_next;
    logic [pbc_pkg::DistW-1:0] best_reg, best_next;
    logic [pbc_pkg::SensW-1:0] sel_reg, sel_next;
    logic [pbc_pkg::MulAW-1:0] dd_reg;
    logic [pbc_pkg::DivisorW-1:0] tsq_reg;

    logic                      m_valid_reg;
    pbc_pkg::out_beat_t        m_data_reg;

    logic [pbc_pkg::DistW-1:0] cur_d;
    logic                      take;
    logic                      beep_next;
    logic                      slot_free;
    logic                      fire;

    logic [pbc_pkg::MulAW-1:0] mul_a;
    logic [pbc_pkg::MulBW-1:0] mul_b;
    logic [pbc_pkg::ProdW-1:0] mul_p;

    logic signed [pbc_pkg::MaxW:0] span_s;
    logic                      span_neg;
    logic [pbc_pkg::MaxW-1:0]  span_mag;

    logic                      div_start;
    logic [pbc_pkg::QuoW-1:0]  quo;
    pbc_pkg::div_sts_t         div_sts;

    logic [pbc_pkg::QuoW+1:0]  off_full;
    logic [pbc_pkg::QuoW-1:0]  off_base;
    logic [pbc_pkg::QuoW-1:0]  off_h;
    logic signed [pbc_pkg::DistW:0] approach;
    logic                      beep_mode;
    pbc_pkg::out_beat_t        res;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= pbc_pkg::THR_RESET;
            min_reg  <= pbc_pkg::MIN_RESET;
            max_reg  <= pbc_pkg::MAX_RESET;
            beep_reg <= pbc_pkg::BEEP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                pbc_pkg::REG_THRESHOLD: thr_reg  <= cfg_wdata[pbc_pkg::ThrW-1:0];
                pbc_pkg::REG_MIN_PAUSE: min_reg  <= cfg_wdata[pbc_pkg::MinW-1:0];
                pbc_pkg::REG_MAX_PAUSE: max_reg  <= cfg_wdata[pbc_pkg::MaxW-1:0];
                pbc_pkg::REG_BEEP_LEN:  beep_reg <= cfg_wdata[pbc_pkg::BeepW-1:0];
                default: ;
            endcase
        end
    end

    // one sensor per scan cycle, strict compare keeps the earlier one on a tie
    always_comb begin
        case (idx_reg)
            pbc_pkg::SENSOR_FRONT: cur_d = in_reg.dist_front;
            pbc_pkg::SENSOR_LEFT:  cur_d = in_reg.dist_left;
            pbc_pkg::SENSOR_RIGHT: cur_d = in_reg.dist_right;
            pbc_pkg::SENSOR_BACK:  cur_d = in_reg.dist_back;
            default:               cur_d = in_reg.dist_front;
        endcase
    end

    assign take       = (cur_d != '0) && (cur_d < thr_reg) && (!found_reg || cur_d < best_reg);
    assign found_next = found_reg | take;
    assign best_next  = take ? cur_d : best_reg;
    assign sel_next   = take ? idx_reg : sel_reg;
    assign beep_next  = found_next && (best_next >= pbc_pkg::CONT_LIMIT);

    assign span_s   = $signed({1'b0, max_reg}) - $signed({3'b000, min_reg});
    assign span_neg = span_s[pbc_pkg::MaxW];
    assign span_mag = span_neg ? pbc_pkg::MaxW'(-span_s) : span_s[pbc_pkg::MaxW-1:0];

    // shared multiplier: d*d, then thr*thr, then d*d*|span|
    always_comb begin
        case (state_reg)
            ST_SQ: begin
                mul_a = {{(pbc_pkg::MulAW - pbc_pkg::DistW){1'b0}}, best_reg};
                mul_b = {{(pbc_pkg::MulBW - pbc_pkg::DistW){1'b0}}, best_reg};
            end
            ST_THR: begin
                mul_a = {{(pbc_pkg::MulAW - pbc_pkg::ThrW){1'b0}}, thr_reg};
                mul_b = {{(pbc_pkg::MulBW - pbc_pkg::ThrW){1'b0}}, thr_reg};
            end
            default: begin
                mul_a = dd_reg;
                mul_b = span_mag;
            end
        endcase
    end

    assign mul_p = {{pbc_pkg::MulBW{1'b0}}, mul_a} * {{pbc_pkg::MulAW{1'b0}}, mul_b};

    assign div_start = (state_reg == ST_PROD);

    pbc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul_p),
        .divisor  (tsq_reg),
        .quotient (quo),
        .sts      (div_sts)
    );

    // quotient magnitude never exceeds |span|, so the result stays in range
    assign off_full = span_neg
                    ? ({4'b0000, min_reg} - {2'b00, quo})
                    : ({4'b0000, min_reg} + {2'b00, quo});
    assign off_base = off_full[pbc_pkg::QuoW-1:0];
    assign approach = $signed({1'b0, last_reg}) - $signed({1'b0, best_reg});
    assign off_h    = (approach > $signed(pbc_pkg::APPROACH_LIMIT)) ? (off_base >> 1) : off_base;
    assign beep_mode = found_reg && (best_reg >= pbc_pkg::CONT_LIMIT);

    always_comb begin
        res = '0;
        res.pause_ms = pbc_pkg::IDLE_PAUSE;
        if (found_reg) begin
            res.obstacle_seen  = 1'b1;
            res.nearest_sensor = sel_reg;
            res.tone_hz        = pbc_pkg::tone_of(sel_reg);
            if (beep_mode) begin
                res.beep_ms  = beep_reg;
                res.pause_ms = {1'b0, off_h} + pbc_pkg::LOOP_WAIT;
            end else begin
                res.continuous_tone = 1'b1;
            end
        end
    end

    assign slot_free = !m_valid_reg || m_ready;
    assign fire      = (state_reg == ST_FIN) && slot_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_SCAN;
            ST_SCAN: begin
                if (idx_reg == pbc_pkg::SENSOR_BACK) begin
                    state_next = beep_next ? ST_SQ : ST_FIN;
                end
            end
            ST_SQ:   state_next = ST_THR;
            ST_THR:  state_next = ST_PROD;
            ST_PROD: state_next = ST_DIV;
            ST_DIV:  if (div_sts.done) state_next = ST_FIN;
            ST_FIN:  if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            last_reg    <= pbc_pkg::THR_RESET;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && s_valid) begin
                found_reg <= 1'b0;
                idx_reg   <= '0;
            end else if (state_reg == ST_SCAN) begin
                found_reg <= found_next;
                idx_reg   <= idx_reg + 1'b1;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
                if (!found_reg) begin
                    last_reg <= thr_reg;
                end else if (beep_mode) begin
                    last_reg <= best_reg;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            in_reg <= s_data;
        end
        if (state_reg == ST_SCAN) begin
            best_reg <= best_next;
            sel_reg  <= sel_next;
        end
        if (state_reg == ST_SQ) begin
            dd_reg <= mul_p[pbc_pkg::MulAW-1:0];
        end
        if (state_reg == ST_THR) begin
            tsq_reg <= mul_p[pbc_pkg::DivisorW-1:0];
        end
        if (fire) begin
            m_data_reg <= res;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hw/rtl/pbc_checker.sv]
// pbc_checker: port-level assertions for proximity_beep_controller_core, with its bind
// depends on pbc_pkg and the top level's port list
module pbc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input pbc_pkg::out_beat_t            m_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // the block works on one beat at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a beat is in progress");

    a_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.obstacle_seen |->
            m_data.tone_hz == '0 && m_data.beep_ms == '0 && !m_data.continuous_tone
            && m_data.pause_ms == pbc_pkg::IDLE_PAUSE)
        else $error("no-obstacle beat is not silent");

    a_continuous: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.continuous_tone |->
            m_data.obstacle_seen && m_data.beep_ms == '0
            && m_data.pause_ms == pbc_pkg::IDLE_PAUSE)
        else $error("continuous tone beat is malformed");

    a_tone_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.obstacle_seen |->
            (m_data.nearest_sensor == pbc_pkg::SENSOR_FRONT
                && m_data.tone_hz == pbc_pkg::TONE_FRONT)
            || (m_data.nearest_sensor == pbc_pkg::SENSOR_LEFT
                && m_data.tone_hz == pbc_pkg::TONE_LEFT)
            || (m_data.nearest_sensor == pbc_pkg::SENSOR_RIGHT
                && m_data.tone_hz == pbc_pkg::TONE_RIGHT)
            || (m_data.nearest_sensor == pbc_pkg::SENSOR_BACK
                && m_data.tone_hz == pbc_pkg::TONE_BACK))
        else $error("tone does not match nearest sensor");

endmodule

bind proximity_beep_controller_core pbc_checker u_pbc_checker (.*);
